FILE: rtl/pressure_frame_oversample_averager_macros.svh
// Assertion macros shared by the averager RTL.
`ifndef PRESSURE_FRAME_OVERSAMPLE_AVERAGER_MACROS_SVH
`define PRESSURE_FRAME_OVERSAMPLE_AVERAGER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define PFOA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PFOA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PFOA_ASSERT_IMP(lbl, ante, cons, msg)
`define PFOA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/pfoa_pkg.sv
// Shared types and constants for the pressure frame averager.
package pfoa_pkg;

	localparam int MAX_SAMPLES_DEF = 16;

	localparam int STAT_W  = 2;
	localparam int PRESS_W = 14;
	localparam int TEMP_W  = 11;
	localparam int CFG_W   = 5;
	localparam int FRAME_W = 32;
	localparam int OUT_W   = 32;

	// frame field masks
	localparam logic [7:0] STAT_MASK   = 8'hc0;
	localparam logic [7:0] PRESS_MASK  = 8'h3f;
	localparam logic [7:0] TEMP_LO_MASK = 8'he0;

	typedef enum logic [STAT_W-1:0] {
		STAT_NORMAL = 2'd0,
		STAT_CMD    = 2'd1,
		STAT_STALE  = 2'd2,
		STAT_FAULT  = 2'd3
	} status_t;

	// sequencer to accumulate/divide lane
	typedef struct packed {
		logic clr;       // zero sum and remainder
		logic load;      // take a new operand
		logic add_step;  // one bit of serial add
		logic div_step;  // one quotient bit of restoring divide
	} lane_ctrl_t;

endpackage

FILE: rtl/pfoa_lane.sv
// Bit-serial accumulator and restoring divider for one averaged field.
`include "pressure_frame_oversample_averager_macros.svh"

module pfoa_lane #(
	parameter int DW = 14,
	parameter int CW = 5,
	parameter int SW = 19
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pfoa_pkg::lane_ctrl_t   ctrl,
	input  logic [DW-1:0]          operand,
	input  logic [CW-1:0]          divisor,
	output logic [DW-1:0]          quotient
);
	import pfoa_pkg::*;

	logic [SW-1:0] sum_q;
	logic [DW-1:0] opnd_q;
	logic          carry_q;
	logic [CW-1:0] rem_q;

	logic [1:0]    bit_sum;
	logic [CW:0]   rem_shift;
	logic [CW:0]   div_ext;
	logic [CW:0]   rem_diff;
	logic          q_bit;

	assign bit_sum   = {1'b0, sum_q[0]} + {1'b0, opnd_q[0]} + {1'b0, carry_q};
	assign rem_shift = {rem_q, sum_q[SW-1]};
	assign div_ext   = {1'b0, divisor};
	assign rem_diff  = rem_shift - div_ext;
	assign q_bit     = (rem_shift >= div_ext);

	// sum rotates LSB first while adding; during divide the quotient
	// shifts in from the bottom as the dividend leaves the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			opnd_q  <= '0;
			carry_q <= 1'b0;
			rem_q   <= '0;
		end else begin
			if (ctrl.clr) begin
				sum_q <= '0;
				rem_q <= '0;
			end else if (ctrl.add_step) begin
				sum_q   <= {bit_sum[0], sum_q[SW-1:1]};
				opnd_q  <= {1'b0, opnd_q[DW-1:1]};
				carry_q <= bit_sum[1];
			end else if (ctrl.div_step) begin
				sum_q <= {sum_q[SW-2:0], q_bit};
				rem_q <= q_bit ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
			end
			if (ctrl.load) begin
				opnd_q  <= operand;
				carry_q <= 1'b0;
			end
		end
	end

	assign quotient = sum_q[DW-1:0];

	`PFOA_ASSERT_IMP(a_rem_below_div, ctrl.div_step, rem_q < divisor, "lane remainder out of range")
	`PFOA_ASSERT_IMP(a_div_nonzero, ctrl.div_step, divisor != '0, "lane divide by zero")
	`PFOA_ASSERT_IMP(a_ctrl_excl, ctrl.load || ctrl.clr, !ctrl.add_step && !ctrl.div_step,
		"lane load or clear during serial work")

endmodule

FILE: rtl/pressure_frame_oversample_averager.sv
// Top level: frame decode, batch sequencer and averaged result output.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: four frame bytes
//  m_      | out | m_tvalid/m_tready  | m_tuser: status; m_tdata: averages
//  cfg_    | in  | cfg_we (no wait)   | cfg_data: num_samples
//
// A frame is taken while idle, then both sums are updated one bit per cycle
// across their SW = 14 + clog2(MAX_SAMPLES+1) bits (19 at the default).
// A frame that fills the batch then runs the bit-serial restoring divide,
// then the result moves to the output register once the output is free.
// A non-normal status skips the serial work and goes straight to the result state.
// arst_n clears control state, counters and sums; num_samples resets to max.
// A held output only stalls the block when the next result is ready to go.
`include "pressure_frame_oversample_averager_macros.svh"

module pressure_frame_oversample_averager #(
	parameter int MAX_SAMPLES = pfoa_pkg::MAX_SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// frame_byte0 [7:0], frame_byte1 [15:8], frame_byte2 [23:16], frame_byte3 [31:24]
	input  logic [pfoa_pkg::FRAME_W-1:0]  s_tdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// pressure_average [13:0], temperature_average [24:14], zero above
	output logic [pfoa_pkg::OUT_W-1:0]    m_tdata,
	// sensor_status [1:0]
	output logic [pfoa_pkg::STAT_W-1:0]   m_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          cfg_we,
	input  logic [pfoa_pkg::CFG_W-1:0]    cfg_data
);
	import pfoa_pkg::*;

	localparam int CW    = $clog2(MAX_SAMPLES + 1);  // frame count width
	localparam int SW    = PRESS_W + CW;             // sum width, both lanes
	localparam int STEPW = $clog2(SW);
	localparam int PADW  = OUT_W - PRESS_W - TEMP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_DIV,
		ST_RES
	} state_t;

	state_t              state_q;
	logic [STEPW-1:0]    step_q;
	logic [CW-1:0]       cnt_q;      // frames in current batch
	logic [CW-1:0]       num_q;      // num_samples
	logic                done_q;     // batch full after this add
	status_t             stat_q;
	logic [PRESS_W-1:0]  press_avg_q;
	logic [TEMP_W-1:0]   temp_avg_q;
	logic [STAT_W-1:0]   m_stat_q;
	logic                m_valid_q;

	// frame decode
	logic [7:0]          b0, b1, b2, b3;
	status_t             frm_stat;
	logic [PRESS_W-1:0]  frm_press;
	logic [TEMP_W-1:0]   frm_temp;
	logic                acc;
	logic                acc_normal;
	logic                out_free;
	logic                last_step;
	logic [CW-1:0]       cnt_inc;
	logic                cfg_ok;
	lane_ctrl_t          ctrl;
	logic [PRESS_W-1:0]  press_quo;
	logic [TEMP_W-1:0]   temp_quo;

	assign b0 = s_tdata[7:0];
	assign b1 = s_tdata[15:8];
	assign b2 = s_tdata[23:16];
	assign b3 = s_tdata[31:24];

	assign frm_stat  = status_t'(b0[7:6] & STAT_MASK[7:6]);
	assign frm_press = {b0[5:0] & PRESS_MASK[5:0], b1};
	// temperature: byte 2, then the top three bits of byte 3
	assign frm_temp  = {b2, b3[7:5] & TEMP_LO_MASK[7:5]};

	assign s_tready   = (state_q == ST_IDLE);
	assign acc        = s_tvalid && s_tready;
	assign acc_normal = acc && (frm_stat == STAT_NORMAL);
	assign out_free   = !m_valid_q || m_tready;
	assign last_step  = (step_q == STEPW'(SW - 1));
	assign cnt_inc    = CW'(cnt_q + 1'b1);

	// out-of-range writes store the maximum
	assign cfg_ok = (cfg_data != '0) && (int'(cfg_data) <= MAX_SAMPLES);

	always_comb begin
		ctrl          = '0;
		ctrl.load     = acc_normal;
		ctrl.clr      = (acc && !acc_normal) || (state_q == ST_RES && out_free);
		ctrl.add_step = (state_q == ST_ADD);
		ctrl.div_step = (state_q == ST_DIV);
	end

	pfoa_lane #(.DW(PRESS_W), .CW(CW), .SW(SW)) u_press (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.operand  (frm_press),
		.divisor  (cnt_q),
		.quotient (press_quo)
	);

	pfoa_lane #(.DW(TEMP_W), .CW(CW), .SW(SW)) u_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.operand  (frm_temp),
		.divisor  (cnt_q),
		.quotient (temp_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			cnt_q     <= '0;
			num_q     <= CW'(MAX_SAMPLES);
			done_q    <= 1'b0;
			stat_q    <= STAT_NORMAL;
			m_valid_q <= 1'b0;
			m_stat_q  <= '0;
		end else begin
			if (cfg_we) begin
				num_q <= cfg_ok ? CW'(cfg_data) : CW'(MAX_SAMPLES);
			end
			// a new result may replace the one leaving in the same cycle
			if (state_q == ST_RES && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_normal) begin
						cnt_q   <= cnt_inc;
						done_q  <= (cnt_inc >= num_q);
						stat_q  <= STAT_NORMAL;
						step_q  <= '0;
						state_q <= ST_ADD;
					end else if (acc) begin
						// non-normal status drops the batch
						cnt_q   <= '0;
						stat_q  <= frm_stat;
						state_q <= ST_RES;
					end
				end
				ST_ADD: begin
					if (last_step) begin
						step_q  <= '0;
						state_q <= done_q ? ST_DIV : ST_IDLE;
					end else begin
						step_q <= STEPW'(step_q + 1'b1);
					end
				end
				ST_DIV: begin
					if (last_step) begin
						step_q  <= '0;
						state_q <= ST_RES;
					end else begin
						step_q <= STEPW'(step_q + 1'b1);
					end
				end
				ST_RES: begin
					if (out_free) begin
						m_stat_q  <= stat_q;
						cnt_q     <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_RES && out_free) begin
			press_avg_q <= (stat_q == STAT_NORMAL) ? press_quo : '0;
			temp_avg_q  <= (stat_q == STAT_NORMAL) ? temp_quo : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_stat_q;
	assign m_tdata  = {{PADW{1'b0}}, temp_avg_q, press_avg_q};

	`PFOA_ASSERT_IMP(a_cnt_max, state_q != ST_IDLE || cnt_q != '0, cnt_q <= CW'(MAX_SAMPLES),
		"frame count above maximum")
	`PFOA_ASSERT_NXT(a_fault_clears, acc && !acc_normal, state_q == ST_RES && cnt_q == '0,
		"non-normal frame did not drop the batch")
	`PFOA_ASSERT_NXT(a_res_out, state_q == ST_RES && out_free,
		m_tvalid && state_q == ST_IDLE && cnt_q == '0, "result not moved to output")

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the pressure frame oversample averager.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pfoa_pkg::*;

	// covers a normal frame's add, divide and result steps in the block, padded
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASES        = 3;
	localparam int SEGMENTS      = 7;

	// expected output transfer: status in tuser, averages in tdata
	typedef struct packed {
		status_t          status;
		logic [PRESS_W-1:0] press;
		logic [TEMP_W-1:0]  temp;
	} avg_result_t;

	typedef enum logic {
		ROW_FRAME,
		ROW_CONFIG
	} row_kind_t;

	// directed row: a frame (bytes 3..0 as written) or a num_samples write;
	// pinned rows carry the expected average typed in by hand
	typedef struct {
		row_kind_t   kind;
		logic [31:0] value;
		bit          pinned;
		avg_result_t pinned_res;
	} stim_row_t;

	localparam avg_result_t ZERO_RES = '{STAT_NORMAL, 14'd0, 11'd0};
	localparam int DIRECTED_ROWS = 29;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic [FRAME_W-1:0]  s_tdata  = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic [STAT_W-1:0]   m_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic                cfg_we   = 1'b0;
	logic [CFG_W-1:0]    cfg_data = '0;

	// predictor copy of the block state
	logic [CFG_W-1:0] frames_per_avg;
	logic [4:0]       frames_in_batch;
	logic [17:0]      press_acc;
	logic [14:0]      temp_acc;

	avg_result_t avg_expected_q[$];

	int tx_idle_pct = 13;
	int rx_idle_pct = 60;
	int hold_left   = 0;
	int mismatches  = 0;
	int frames_sent = 0;
	int averages_checked = 0;
	int cfg_writes  = 0;

	// frame bytes read right to left: byte3 byte2 byte1 byte0
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_CONFIG, 32'd1,        1'b0, ZERO_RES},
		// all-zero frame, batch of one
		'{ROW_FRAME,  32'h00000000, 1'b1, '{STAT_NORMAL, 14'd0, 11'd0}},
		// every field at its top
		'{ROW_FRAME,  32'hffffff3f, 1'b1, '{STAT_NORMAL, 14'd16383, 11'd2047}},
		// byte3 low five bits do not reach the temperature
		'{ROW_FRAME,  32'h1fffff3f, 1'b1, '{STAT_NORMAL, 14'd16383, 11'd2040}},
		'{ROW_FRAME,  32'he0000000, 1'b1, '{STAT_NORMAL, 14'd0, 11'd7}},
		// non-normal status zeroes both averages
		'{ROW_FRAME,  32'hffffff40, 1'b1, '{STAT_CMD, 14'd0, 11'd0}},
		'{ROW_FRAME,  32'h00000080, 1'b1, '{STAT_STALE, 14'd0, 11'd0}},
		'{ROW_FRAME,  32'hffffffc0, 1'b1, '{STAT_FAULT, 14'd0, 11'd0}},
		'{ROW_CONFIG, 32'd4,        1'b0, ZERO_RES},
		'{ROW_FRAME,  32'h5a3c0012, 1'b0, ZERO_RES},
		'{ROW_FRAME,  32'ha5c3ff2d, 1'b0, ZERO_RES},
		'{ROW_FRAME,  32'h00001f3f, 1'b0, ZERO_RES},
		// stale frame in a batch holding three of four frames throws the batch away
		'{ROW_FRAME,  32'h12345680, 1'b1, '{STAT_STALE, 14'd0, 11'd0}},
		'{ROW_FRAME,  32'h77e10a05, 1'b0, ZERO_RES},
		'{ROW_FRAME,  32'h20f0331a, 1'b0, ZERO_RES},
		'{ROW_FRAME,  32'hc0019f00, 1'b0, ZERO_RES},
		'{ROW_FRAME,  32'h3e7e552c, 1'b0, ZERO_RES},
		// zero stores the maximum
		'{ROW_CONFIG, 32'd0,        1'b0, ZERO_RES},
		'{ROW_FRAME,  32'hffffff3f, 1'b0, ZERO_RES},
		'{ROW_FRAME,  32'h00ffff3f, 1'b0, ZERO_RES},
		'{ROW_FRAME,  32'h60a01234, 1'b0, ZERO_RES},
		// shrink below the count already taken: next frame closes over four
		'{ROW_CONFIG, 32'd2,        1'b0, ZERO_RES},
		'{ROW_FRAME,  32'h8e13c701, 1'b0, ZERO_RES},
		'{ROW_CONFIG, 32'd31,       1'b0, ZERO_RES},
		'{ROW_FRAME,  32'h40404001, 1'b0, ZERO_RES},
		'{ROW_FRAME,  32'h000000c0, 1'b1, '{STAT_FAULT, 14'd0, 11'd0}},
		'{ROW_CONFIG, 32'd17,       1'b0, ZERO_RES},
		'{ROW_FRAME,  32'h0000007f, 1'b1, '{STAT_CMD, 14'd0, 11'd0}},
		'{ROW_FRAME,  32'h000000bf, 1'b1, '{STAT_STALE, 14'd0, 11'd0}}
	};

	pressure_frame_oversample_averager #(
		.MAX_SAMPLES(MAX_SAMPLES_DEF)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	task automatic clear_batch();
		frames_in_batch = '0;
		press_acc       = '0;
		temp_acc        = '0;
	endtask

	// Decode one frame and accumulate; a non-normal status reports at once.
	task automatic average_frame(input logic [31:0] frame, output bit emits,
			output avg_result_t res);
		logic [7:0]         b0;
		logic [7:0]         b1;
		logic [7:0]         b2;
		logic [7:0]         b3;
		logic [PRESS_W-1:0] press;
		logic [TEMP_W-1:0]  temp;
		b0 = frame[7:0];
		b1 = frame[15:8];
		b2 = frame[23:16];
		b3 = frame[31:24];
		res = ZERO_RES;
		emits = 1'b0;
		if (b0[7:6] != STAT_NORMAL) begin
			clear_batch();
			res.status = status_t'(b0[7:6]);
			emits = 1'b1;
		end else begin
			press = {b0[5:0], b1};
			temp  = {b2, b3[7:5]};
			press_acc = press_acc + 18'(press);
			temp_acc  = temp_acc + 15'(temp);
			frames_in_batch = frames_in_batch + 5'd1;
			// count may already exceed a lowered setting: divide by the true count
			if (frames_in_batch >= frames_per_avg) begin
				res.press = PRESS_W'(press_acc / 18'(frames_in_batch));
				res.temp  = TEMP_W'(temp_acc / 15'(frames_in_batch));
				emits = 1'b1;
				clear_batch();
			end
		end
	endtask

	// one register write at the next edge; then we drops before the task returns
	task automatic write_num_samples(input logic [CFG_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (value >= 1 && value <= MAX_SAMPLES_DEF)
			frames_per_avg = value;
		else
			frames_per_avg = CFG_W'(MAX_SAMPLES_DEF);
		cfg_writes++;
		@(posedge clk);
	endtask

	// Offer one frame, with random idle cycles first; predict on transfer.
	task automatic send_frame(input logic [31:0] frame, input bit pinned,
			input avg_result_t pinned_res);
		bit          emits;
		avg_result_t res;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= frame;
		do @(posedge clk); while (!s_tready);
		frames_sent++;
		average_frame(frame, emits, res);
		if (pinned)
			res = pinned_res;
		if (emits)
			avg_expected_q.push_back(res);
	endtask

	// Stop offering, let every expected average out, then let the serial
	// lanes finish a frame that produced nothing.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (avg_expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] random_frame();
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		int unsigned pick;
		b0 = 8'($urandom);
		b1 = 8'($urandom);
		b2 = 8'($urandom);
		b3 = 8'($urandom);
		// mostly normal frames so batches fill; the rest any status
		if ($urandom_range(0, 19) < 17)
			b0[7:6] = STAT_NORMAL;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			b0[5:0] = '1; b1 = '1; b2 = '1; b3[7:5] = '1;
		end else if (pick == 1) begin
			b0[5:0] = '0; b1 = '0; b2 = '0; b3[7:5] = '0;
		end
		return {b3, b2, b1, b0};
	endfunction

	function automatic logic [CFG_W-1:0] random_num_samples();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		case (pick)
			6: return CFG_W'(MAX_SAMPLES_DEF);
			7: return '0;
			8: return CFG_W'($urandom_range(MAX_SAMPLES_DEF + 1, 31));
			9: return CFG_W'($urandom_range(5, MAX_SAMPLES_DEF - 1));
			default: return CFG_W'($urandom_range(1, 4));
		endcase
	endfunction

	// receiver: random idling, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// every output transfer against the oldest expected average
	always @(posedge clk) begin
		avg_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (avg_expected_q.size() == 0) begin
				$error("unexpected transfer: status %0d press %0d temp %0d",
					m_tuser, m_tdata[13:0], m_tdata[24:14]);
				mismatches++;
			end else begin
				want = avg_expected_q.pop_front();
				averages_checked++;
				if (m_tuser !== want.status) begin
					$error("sensor_status: expected %0d, got %0d", want.status, m_tuser);
					mismatches++;
				end
				if (m_tdata[13:0] !== want.press) begin
					$error("pressure_average: expected %0d, got %0d",
						want.press, m_tdata[13:0]);
					mismatches++;
				end
				if (m_tdata[24:14] !== want.temp) begin
					$error("temperature_average: expected %0d, got %0d",
						want.temp, m_tdata[24:14]);
					mismatches++;
				end
				if (m_tdata[31:25] !== '0) begin
					$error("tdata padding: expected 0, got %0h", m_tdata[31:25]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int n_frames;
		int ph;
		int seg;
		frames_per_avg = CFG_W'(MAX_SAMPLES_DEF);
		clear_batch();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table, sender 13% idle, receiver 60% idle
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CONFIG) begin
				wait_idle();
				write_num_samples(directed_rows[i].value[CFG_W-1:0]);
			end else begin
				send_frame(directed_rows[i].value, directed_rows[i].pinned,
					directed_rows[i].pinned_res);
			end
		end

		// random segments; each starts from an idle block with a new setting,
		// often mid-batch since leftover frames stay counted
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 13; rx_idle_pct = 60; end
				1: begin tx_idle_pct = 60; rx_idle_pct = 13; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (seg = 0; seg < SEGMENTS; seg++) begin
				wait_idle();
				if (ph == PHASES - 1 && seg == 0) begin
					// one result per frame while the receiver holds off:
					// output backs up and s_tready must drop
					write_num_samples(5'd1);
					hold_left = HOLD_CYCLES;
				end else begin
					write_num_samples(random_num_samples());
				end
				n_frames = $urandom_range(40, 90);
				repeat (n_frames) send_frame(random_frame(), 1'b0, ZERO_RES);
			end
		end
		wait_idle();

		$display("covered %0d frames, %0d averages and status reports, %0d num_samples writes",
			frames_sent, averages_checked, cfg_writes);
		$display("settings 0..31 incl. out of range, mid-batch shrink, long output hold");
		if (mismatches == 0 && avg_expected_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$error("timeout with %0d averages still expected", avg_expected_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/pfoa_pkg.sv
rtl/pfoa_lane.sv
rtl/pressure_frame_oversample_averager.sv
test/testbench.sv
